>>> hdl/sha256_pkg.sv
// package: sha-256 constants, round function helpers and shared types
`default_nettype none
package sha256_pkg;

  localparam int unsigned RoundsNum = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned HashWords = 8;
  localparam int unsigned LenOffset = 56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [RoundsNum] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] HashInit [HashWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_if.sv
// interfaces: valid/ready channels for input bytes and digest words
`default_nettype none
interface sha256_in_if;
  logic                 valid;
  logic                 ready;
  sha256_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input ready, input payload);
endinterface

interface sha256_out_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input ready, input payload);
endinterface
`default_nettype wire

>>> hdl/sha256_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module sha256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/sha256_byte_stream_hasher_unit.sv
// top level: sha-256 hasher fed one byte per transfer, digest out as eight words
//
// usage
//   in_ch  : one transfer per item {data_byte, has_byte, last}; has_byte=0
//            carries no message byte, last ends the message (a byte on the
//            same transfer is taken first)
//   out_ch : eight transfers per message, digest words 0..7 in order,
//            last_word set on word 7
// timing
//   a byte that does not fill the block leaves in_ch.ready high; the 64th
//   byte starts a compression (load, 64 rounds, add) that keeps in_ch.ready
//   low until the add has folded the working vars into the chaining words
//   on the last transfer, padding writes one byte a cycle up to byte 63 and
//   the block is compressed; a further pad block carries the length when the
//   marker lands at or past byte 56 or the last transfer fills the block
//   digest words follow one per cycle from an output register unless stalled
// stalls and reset
//   a stalled receiver holds the word and the block in its emit state, with
//   in_ch.ready low; rst_ni restores the initial hash words, fill and count
`default_nettype none
module sha256_byte_stream_hasher_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  sha256_in_if.sink        in_ch,
  sha256_out_if.source     out_ch
);

  // controller states
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,  // write pad bytes one at a time
    StLoad  = 6'b000100,  // prime the round engine
    StRound = 6'b001000,  // one round a cycle
    StAdd   = 6'b010000,  // fold working vars into chaining words
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] h_q [sha256_pkg::HashWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;       // round counter
  logic        fin_q;       // message ends, padding in progress
  logic        mark_q;      // 0x80 marker not yet written
  logic        lenblk_q;    // current pad block carries the length
  logic [2:0]  emit_q;      // next digest word to load
  logic        out_valid_q;
  sha256_pkg::out_item_t out_q;

  logic in_fire, out_fire;
  logic [5:0] pad_pos;      // where the marker lands

  // block memory: bytes merged into words, word read for round loading
  logic        bw_we;
  logic [3:0]  bw_addr, br_addr;
  logic [31:0] bw_data, br_data;
  logic [31:0] word_acc_q;  // assembling the current word

  sha256_ram #(.Width(32), .Depth(16)) u_block (
    .clk_i   (clk_i),
    .we_i    (bw_we),
    .waddr_i (bw_addr),
    .wdata_i (bw_data),
    .raddr_i (br_addr),
    .rdata_o (br_data)
  );

  // schedule window: w_q[15] newest, shifted each round
  logic [31:0] w_q [16];

  logic [7:0]  pad_byte;
  logic        byte_we;
  logic [7:0]  byte_val;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_q == StIdle);
  assign out_ch.valid = out_valid_q;
  assign out_ch.payload = out_q;
  assign pad_pos = in_ch.payload.has_byte ? fill_q + 6'd1 : fill_q;

  // byte path: accumulate into word_acc, write the whole word each byte
  always_comb begin
    bw_we   = byte_we;
    bw_addr = fill_q[5:2];
    unique case (fill_q[1:0])
      2'd0: bw_data = {byte_val, 24'd0};
      2'd1: bw_data = {word_acc_q[31:24], byte_val, 16'd0};
      2'd2: bw_data = {word_acc_q[31:16], byte_val, 8'd0};
      default: bw_data = {word_acc_q[31:8], byte_val};
    endcase
  end

  // pad contents by position: zeros, then the big-endian bit count
  always_comb begin
    pad_byte = 8'd0;
    if (lenblk_q && fill_q >= 6'(sha256_pkg::LenOffset)) begin
      pad_byte = bits_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    byte_we  = 1'b0;
    byte_val = in_ch.payload.data_byte;
    if (in_fire && in_ch.payload.has_byte) begin
      byte_we = 1'b1;
    end else if (state_q == StPad) begin
      byte_we  = 1'b1;
      byte_val = mark_q ? sha256_pkg::PadByte : pad_byte;
    end
  end

  // word t is addressed in the cycle before round t
  assign br_addr = (state_q == StRound) ? rnd_q[3:0] + 4'd1 : 4'd0;

  // round datapath
  logic [31:0] wt, w_new, t1, t2, kt;
  assign kt = sha256_pkg::RoundK[rnd_q];
  assign w_new = w_q[0] + sha256_pkg::sig0(w_q[1]) + w_q[9] + sha256_pkg::sig1(w_q[14]);
  assign wt = (rnd_q < 6'd16) ? br_data : w_new;
  assign t1 = hh_q + sha256_pkg::bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + kt + wt;
  assign t2 = sha256_pkg::bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) begin
        if (in_ch.payload.has_byte && fill_q == 6'd63) state_d = StLoad;
        else if (in_ch.payload.last) state_d = StPad;
      end
      StPad:   if (fill_q == 6'd63) state_d = StLoad;
      StLoad:  state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StAdd;
      StAdd: begin
        if (!fin_q) state_d = StIdle;
        else if (lenblk_q && !mark_q) state_d = StEmit;
        else state_d = StPad;
      end
      StEmit: if (out_fire && out_q.last_word) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::HashInit[i];
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      e_q <= '0; f_q <= '0; g_q <= '0; hh_q <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      mark_q <= 1'b0;
      lenblk_q <= 1'b0;
      emit_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      word_acc_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (in_fire) begin
          if (in_ch.payload.has_byte) begin
            fill_q <= fill_q + 6'd1;
            bits_q <= bits_q + 64'd8;
          end
          fin_q <= in_ch.payload.last;
          mark_q <= 1'b1;
          // length fits behind the marker when it lands before the length field
          lenblk_q <= (pad_pos < 6'(sha256_pkg::LenOffset));
        end
        StPad: begin
          fill_q <= fill_q + 6'd1;
          mark_q <= 1'b0;
        end
        StLoad: begin
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
          e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
          rnd_q <= '0;
        end
        StRound: begin
          hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
          d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wt;
          rnd_q <= rnd_q + 6'd1;
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
          h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
          emit_q <= '0;
          // a following pad block starts at byte 0, so the length always fits
          if (fin_q && !(lenblk_q && !mark_q)) lenblk_q <= 1'b1;
        end
        StEmit: begin
          if (out_fire && out_q.last_word) begin
            // digest done, back to the initial hash words
            out_valid_q <= 1'b0;
            for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::HashInit[i];
            fill_q <= '0;
            bits_q <= '0;
            fin_q <= 1'b0;
            mark_q <= 1'b0;
            lenblk_q <= 1'b0;
          end else if (!out_valid_q || out_fire) begin
            out_q.digest_word <= h_q[emit_q];
            out_q.word_index  <= emit_q;
            out_q.last_word   <= (emit_q == 3'd7);
            out_valid_q <= 1'b1;
            emit_q <= emit_q + 3'd1;
          end
        end
        default: ;
      endcase
      if (byte_we) word_acc_q <= bw_data;
    end
  end

  // assertions
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> state_q == StEmit)
    else $error("digest word outside emit");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> state_q == StIdle)
    else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("digest word dropped or changed while stalled");

endmodule
`default_nettype wire

>>> verif/sha256_checker.sv
// checker: watches the byte and digest channels, predicts sha-256 digests and compares
module sha256_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  sha256_in_if.monitor      in_mon,
  sha256_out_if.monitor     out_mon,
  output int                fail_count_o,
  output int                pending_o
);

  logic [31:0] chain_q [sha256_pkg::HashWords];
  logic [7:0]  block_q [sha256_pkg::BlockBytes];
  int unsigned fill_q;
  logic [63:0] bit_count_q;
  sha256_pkg::out_item_t digest_fifo [$];
  int fails = 0;
  int pend = 0;

  assign fail_count_o = fails;
  assign pending_o = pend;

  function automatic logic [31:0] ror32(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    chain_q[4] += e; chain_q[5] += f; chain_q[6] += g; chain_q[7] += h;
  endtask

  task automatic restart_message();
    foreach (chain_q[i]) chain_q[i] = sha256_pkg::HashInit[i];
    fill_q = 0;
    bit_count_q = '0;
  endtask

  task automatic absorb_item(sha256_pkg::in_item_t it);
    sha256_pkg::out_item_t o;
    if (it.has_byte) begin
      block_q[fill_q] = it.data_byte;
      fill_q = (fill_q + 1) % sha256_pkg::BlockBytes;
      bit_count_q += 64'd8;
      if (fill_q == 0) compress_block();
    end
    if (!it.last) return;
    // pad: marker byte, zeros, length; spill into a second block past the length slot
    block_q[fill_q] = sha256_pkg::PadByte;
    fill_q++;
    if (fill_q > sha256_pkg::LenOffset) begin
      while (fill_q < sha256_pkg::BlockBytes) begin block_q[fill_q] = 8'h00; fill_q++; end
      compress_block();
      fill_q = 0;
    end
    while (fill_q < sha256_pkg::LenOffset) begin block_q[fill_q] = 8'h00; fill_q++; end
    for (int i = 0; i < 8; i++) block_q[63-i] = bit_count_q[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain_q[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_fifo.push_back(o);
    end
    restart_message();
  endtask

  always @(posedge clk_i) begin
    sha256_pkg::out_item_t exp_w;
    sha256_pkg::out_item_t got_w;
    if (!rst_ni) begin
      restart_message();
      digest_fifo.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_item(in_mon.payload);
      if (out_mon.valid && out_mon.ready) begin
        got_w = out_mon.payload;
        if (digest_fifo.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("digest word mismatch: exp none, got %h idx %0d lw %b",
              got_w.digest_word, got_w.word_index, got_w.last_word);
        end else begin
          exp_w = digest_fifo.pop_front();
          if (got_w !== exp_w) begin
            fails++;
            if (fails <= 10)
              $display("digest word mismatch: exp %h idx %0d lw %b, got %h idx %0d lw %b",
                exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                got_w.digest_word, got_w.word_index, got_w.last_word);
          end
        end
      end
    end
    pend = digest_fifo.size();
  end
endmodule

>>> verif/tb.sv
// testbench top: byte stimulus, digest receiver with stalls, and the verdict
module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();
  int fail_count;
  int pending;
  int sent_count = 0;
  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sha256_byte_stream_hasher_unit u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch.sink), .out_ch (out_ch.source)
  );

  sha256_checker u_chk (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_mon (in_ch.monitor), .out_mon (out_ch.monitor),
    .fail_count_o (fail_count), .pending_o (pending)
  );

  // send one transfer, at times with a random idle burst in front of it; called at a
  // falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic [7:0] b, logic hb, logic lst);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= {b, hb, lst};
    // ready seen here holds until the next rising edge
    while (!in_ch.ready) @(negedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  // drop valid and wait until every expected digest word has come
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // one message of len bytes, last flag on its own empty transfer or on the final byte
  task automatic send_message(int len, bit last_alone);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !last_alone && i == len - 1);
    end
    if (last_alone || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver: random stalls, and one long hold when asked
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: empty message, extremes of the byte, short messages
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_message(3, 1'b0);
    // receiver holds off while messages keep coming
    hold_req = 1'b1;
    send_message(0, 1'b1);
    send_message(1, 1'b0);
    send_message(2, 1'b1);
    // sender pauses until every digest word has come
    drain();
    // lengths around the one- and two-block padding split
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b1);
    // random messages, mostly short
    while (sent_count < 290)
      send_message(($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                               : $urandom_range(0, 20),
                   1'($urandom));
    quiet_tail = 1'b1;
    while (sent_count < 330) send_message($urandom_range(0, 8), 1'($urandom));
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
